// ----- src/hue_window_color_keep_assert.svh -----
// Assertion macros shared by the hue window color keep design.
`ifndef HUE_WINDOW_COLOR_KEEP_ASSERT_SVH
`define HUE_WINDOW_COLOR_KEEP_ASSERT_SVH
`ifndef SYNTHESIS
`define HWCK_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("hue window color keep: assertion failed");
`define HWCK_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("hue window color keep: assertion failed");
`else
`define HWCK_ASSERT_SAME(label, clk, rst, pre, post)
`define HWCK_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- src/hwck_pkg.sv -----
`default_nettype none
package hwck_pkg;

   localparam logic [12:0] HUE_FULL     = 13'd5760;
   localparam logic [11:0] HUE_HALF_MAX = 12'd2880;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_HUE_CENTER    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUE_HALFWIDTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_RED    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_GREEN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_BLUE   = 3'd4;

   localparam logic [12:0] RESET_HUE_CENTER    = 13'd0;
   localparam logic [11:0] RESET_HUE_HALFWIDTH = 12'd480;
   localparam logic [7:0]  RESET_WEIGHT_RED    = 8'd77;
   localparam logic [7:0]  RESET_WEIGHT_GREEN  = 8'd150;
   localparam logic [7:0]  RESET_WEIGHT_BLUE   = 8'd29;
   localparam logic [12:0] RESET_HUE_LO        = 13'd5280;
   localparam logic [12:0] RESET_HUE_HI        = 13'd480;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       inside_window;
   } rsp_type;

   typedef struct packed {
      logic [12:0] hue_lo;
      logic [12:0] hue_hi;
      logic        full_window;
      logic [7:0]  weight_red;
      logic [7:0]  weight_green;
      logic [7:0]  weight_blue;
   } cfg_type;

   typedef struct packed {
      req_type     pix;
      logic [20:0] dividend;
      logic [7:0]  divisor;
      logic [15:0] prod_red;
      logic [15:0] prod_green;
      logic [15:0] prod_blue;
   } front_type;

   typedef struct packed {
      req_type     pix;
      logic [7:0]  grey;
      logic [12:0] hue;
   } hue_item_type;

   // One restoring division step: returns the new remainder and the quotient bit.
   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                           input logic [7:0] divisor);
      logic [8:0] trial;
      logic [8:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         return {diff[7:0], 1'b1};
      end
      return {trial[7:0], 1'b0};
   endfunction

endpackage
`default_nettype wire

// ----- src/hue_window_color_keep.sv -----
`default_nettype none
// Color splash filter: each RGB item gets its hue in 1/16 degree steps (0..5759), and a
// pixel whose hue lies in the window around hue_center, hue_halfwidth wide on each side
// and wrapping past zero, leaves unchanged with inside_window set; any other pixel leaves
// as grey at its weighted luma, saturated to 255. The block takes one item every clock
// while the output is not stalled. The hue division by the channel spread runs as a
// restoring divider spread over three register stages behind a stage that forms
// dividend, divisor and the luma products, and ahead of the output register that holds
// the window test. Each stage holds its item under stall while emptier stages upstream
// keep filling. Register writes pass through the raw setting, the reduced center and
// halfwidth, and the window bound registers, and must only be made while idle.
module hue_window_color_keep (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire hwck_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output hwck_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hwck_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hwck_pkg::CSR_DATA_W-1:0]    csr_data
);

   hwck_pkg::cfg_type      cfg;
   logic                   f_valid, f_stall;
   hwck_pkg::front_type    f_data;
   logic                   d_valid, d_stall;
   hwck_pkg::hue_item_type d_data;

   hwck_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hwck_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_stall (f_stall),
      .out_data  (f_data)
   );

   hwck_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_stall (d_stall),
      .out_data  (d_data)
   );

   hwck_select u_select (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (d_valid),
      .in_stall  (d_stall),
      .in_data   (d_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

`include "hue_window_color_keep_assert.svh"

   `HWCK_ASSERT_SAME(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)
   `HWCK_ASSERT_SAME(a_stall_ordered, clock, reset, f_stall, d_stall)
   `HWCK_ASSERT_NEXT(a_handoff_lands, clock, reset, d_valid && !d_stall, rsp_valid)
   `HWCK_ASSERT_SAME(a_grey_equal, clock, reset, rsp_valid && !rsp_data.inside_window,
      rsp_data.red_out == rsp_data.green_out && rsp_data.green_out == rsp_data.blue_out)

endmodule
`default_nettype wire

// ----- src/hwck_csr.sv -----
`default_nettype none
module hwck_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hwck_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hwck_pkg::CSR_DATA_W-1:0]    csr_data,
   output hwck_pkg::cfg_type                       cfg
);

   logic [12:0] center_ff, center_in;
   logic [11:0] halfwidth_ff, halfwidth_in;
   logic [7:0]  w_red_ff, w_red_in;
   logic [7:0]  w_green_ff, w_green_in;
   logic [7:0]  w_blue_ff, w_blue_in;
   logic [12:0] c_ff, c_in;
   logic [11:0] hw_ff, hw_in;
   logic [12:0] lo_ff, lo_in;
   logic [12:0] hi_ff, hi_in;
   logic        full_ff, full_in;
   logic [13:0] lo_sum;
   logic [13:0] hi_sum;
   logic [13:0] hi_wrap;

   assign csr_ready = 1'b1;

   always_comb begin
      center_in    = center_ff;
      halfwidth_in = halfwidth_ff;
      w_red_in     = w_red_ff;
      w_green_in   = w_green_ff;
      w_blue_in    = w_blue_ff;
      if (csr_valid) begin
         case (csr_index)
            hwck_pkg::CSR_HUE_CENTER:    center_in    = csr_data;
            hwck_pkg::CSR_HUE_HALFWIDTH: halfwidth_in = csr_data[11:0];
            hwck_pkg::CSR_WEIGHT_RED:    w_red_in     = csr_data[7:0];
            hwck_pkg::CSR_WEIGHT_GREEN:  w_green_in   = csr_data[7:0];
            hwck_pkg::CSR_WEIGHT_BLUE:   w_blue_in    = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Window bounds are derived over two register steps from the raw settings.
   always_comb begin
      c_in = (center_ff >= hwck_pkg::HUE_FULL) ? center_ff - hwck_pkg::HUE_FULL : center_ff;
      hw_in = (halfwidth_ff > hwck_pkg::HUE_HALF_MAX) ? hwck_pkg::HUE_HALF_MAX : halfwidth_ff;
      lo_sum  = {1'b0, c_ff} + {1'b0, hwck_pkg::HUE_FULL} - {2'b00, hw_ff};
      hi_sum  = {1'b0, c_ff} + {2'b00, hw_ff};
      hi_wrap = hi_sum - {1'b0, hwck_pkg::HUE_FULL};
      lo_in = (c_ff >= {1'b0, hw_ff}) ? c_ff - {1'b0, hw_ff} : lo_sum[12:0];
      hi_in = (hi_sum >= {1'b0, hwck_pkg::HUE_FULL}) ? hi_wrap[12:0] : hi_sum[12:0];
      full_in = (hw_ff == hwck_pkg::HUE_HALF_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff    <= hwck_pkg::RESET_HUE_CENTER;
         halfwidth_ff <= hwck_pkg::RESET_HUE_HALFWIDTH;
         w_red_ff     <= hwck_pkg::RESET_WEIGHT_RED;
         w_green_ff   <= hwck_pkg::RESET_WEIGHT_GREEN;
         w_blue_ff    <= hwck_pkg::RESET_WEIGHT_BLUE;
         c_ff         <= hwck_pkg::RESET_HUE_CENTER;
         hw_ff        <= hwck_pkg::RESET_HUE_HALFWIDTH;
         lo_ff        <= hwck_pkg::RESET_HUE_LO;
         hi_ff        <= hwck_pkg::RESET_HUE_HI;
         full_ff      <= 1'b0;
      end else begin
         center_ff    <= center_in;
         halfwidth_ff <= halfwidth_in;
         w_red_ff     <= w_red_in;
         w_green_ff   <= w_green_in;
         w_blue_ff    <= w_blue_in;
         c_ff         <= c_in;
         hw_ff        <= hw_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         full_ff      <= full_in;
      end
   end

   always_comb begin
      cfg.hue_lo       = lo_ff;
      cfg.hue_hi       = hi_ff;
      cfg.full_window  = full_ff;
      cfg.weight_red   = w_red_ff;
      cfg.weight_green = w_green_ff;
      cfg.weight_blue  = w_blue_ff;
   end

endmodule
`default_nettype wire

// ----- src/hwck_front.sv -----
`default_nettype none
module hwck_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hwck_pkg::cfg_type   cfg,
   input  wire logic                in_valid,
   output logic                     in_stall,
   input  wire hwck_pkg::req_type   in_data,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output hwck_pkg::front_type      out_data
);

   logic                valid_ff, valid_in;
   hwck_pkg::front_type data_ff, data_in;
   logic                take;
   logic [7:0]          r, g, b;
   logic [7:0]          hi, lo, spread;
   logic [11:0]         six_spread;
   logic [11:0]         diff_gb;
   logic [11:0]         num;
   logic                zero_spread;

   assign take     = !valid_ff || !out_stall;
   assign in_stall = !take;

   always_comb begin
      r = in_data.red_in;
      g = in_data.green_in;
      b = in_data.blue_in;
      hi = r;
      lo = r;
      if (g > hi) begin
         hi = g;
      end
      if (b > hi) begin
         hi = b;
      end
      if (g < lo) begin
         lo = g;
      end
      if (b < lo) begin
         lo = b;
      end
      spread      = hi - lo;
      zero_spread = (spread == 8'd0);
      six_spread  = {2'b00, spread, 2'b00} + {3'b000, spread, 1'b0};
      diff_gb     = {4'h0, g} - {4'h0, b};
      if (zero_spread) begin
         num = 12'd0;
      end else if (r == hi) begin
         num = (g >= b) ? diff_gb : diff_gb + six_spread;
      end else if (g == hi) begin
         num = {3'b000, spread, 1'b0} + {4'h0, b} - {4'h0, r};
      end else begin
         num = {2'b00, spread, 2'b00} + {4'h0, r} - {4'h0, g};
      end

      data_in = data_ff;
      if (take) begin
         data_in.pix        = in_data;
         data_in.dividend   = {num[10:0], 10'd0} - {4'h0, num[10:0], 6'd0};
         data_in.divisor    = zero_spread ? 8'd1 : spread;
         data_in.prod_red   = 16'(cfg.weight_red) * 16'(r);
         data_in.prod_green = 16'(cfg.weight_green) * 16'(g);
         data_in.prod_blue  = 16'(cfg.weight_blue) * 16'(b);
      end
      valid_in = take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- src/hwck_div.sv -----
`default_nettype none
module hwck_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                     in_stall,
   input  wire hwck_pkg::front_type  in_data,
   output logic                     out_valid,
   input  wire logic                 out_stall,
   output hwck_pkg::hue_item_type    out_data
);

   // Three stages of the restoring division: quotient bits 12..8, 7..3 and 2..0.
   logic              v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic              take2, take3, take4;
   hwck_pkg::req_type pix2_ff, pix2_in, pix3_ff, pix3_in, pix4_ff, pix4_in;
   logic [7:0]        grey2_ff, grey2_in, grey3_ff, grey3_in, grey4_ff, grey4_in;
   logic [7:0]        d2_ff, d2_in, d3_ff, d3_in;
   logic [7:0]        rem2_ff, rem2_in, rem3_ff, rem3_in;
   logic [7:0]        nlow2_ff, nlow2_in;
   logic [2:0]        nlow3_ff, nlow3_in;
   logic [4:0]        q2_ff, q2_in;
   logic [9:0]        q3_ff, q3_in;
   logic [12:0]       q4_ff, q4_in;
   logic [17:0]       luma_sum;
   logic [8:0]        step;
   logic [7:0]        rem;
   logic [4:0]        qa;
   logic [4:0]        qb;
   logic [2:0]        qc;

   assign take4    = !v4_ff || !out_stall;
   assign take3    = !v3_ff || take4;
   assign take2    = !v2_ff || take3;
   assign in_stall = !take2;

   always_comb begin
      luma_sum = 18'(in_data.prod_red) + 18'(in_data.prod_green) + 18'(in_data.prod_blue);
      rem = in_data.dividend[20:13];
      qa  = 5'd0;
      for (int i = 12; i >= 8; i--) begin
         step      = hwck_pkg::div_step(rem, in_data.dividend[i], in_data.divisor);
         rem       = step[8:1];
         qa[i - 8] = step[0];
      end
      v2_in    = take2 ? in_valid : v2_ff;
      pix2_in  = take2 ? in_data.pix : pix2_ff;
      grey2_in = grey2_ff;
      if (take2) begin
         grey2_in = (luma_sum[17:16] != 2'b00) ? 8'hFF : luma_sum[15:8];
      end
      d2_in    = take2 ? in_data.divisor : d2_ff;
      rem2_in  = take2 ? rem : rem2_ff;
      nlow2_in = take2 ? in_data.dividend[7:0] : nlow2_ff;
      q2_in    = take2 ? qa : q2_ff;
   end

   always_comb begin
      logic [7:0] rem_b;
      logic [8:0] step_b;
      rem_b = rem2_ff;
      qb    = 5'd0;
      for (int i = 7; i >= 3; i--) begin
         step_b    = hwck_pkg::div_step(rem_b, nlow2_ff[i], d2_ff);
         rem_b     = step_b[8:1];
         qb[i - 3] = step_b[0];
      end
      v3_in    = take3 ? v2_ff : v3_ff;
      pix3_in  = take3 ? pix2_ff : pix3_ff;
      grey3_in = take3 ? grey2_ff : grey3_ff;
      d3_in    = take3 ? d2_ff : d3_ff;
      rem3_in  = take3 ? rem_b : rem3_ff;
      nlow3_in = take3 ? nlow2_ff[2:0] : nlow3_ff;
      q3_in    = take3 ? {q2_ff, qb} : q3_ff;
   end

   always_comb begin
      logic [7:0] rem_c;
      logic [8:0] step_c;
      rem_c = rem3_ff;
      qc    = 3'd0;
      for (int i = 2; i >= 0; i--) begin
         step_c = hwck_pkg::div_step(rem_c, nlow3_ff[i], d3_ff);
         rem_c  = step_c[8:1];
         qc[i]  = step_c[0];
      end
      v4_in    = take4 ? v3_ff : v4_ff;
      pix4_in  = take4 ? pix3_ff : pix4_ff;
      grey4_in = take4 ? grey3_ff : grey4_ff;
      q4_in    = take4 ? {q3_ff, qc} : q4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      pix2_ff  <= pix2_in;
      grey2_ff <= grey2_in;
      d2_ff    <= d2_in;
      rem2_ff  <= rem2_in;
      nlow2_ff <= nlow2_in;
      q2_ff    <= q2_in;
      pix3_ff  <= pix3_in;
      grey3_ff <= grey3_in;
      d3_ff    <= d3_in;
      rem3_ff  <= rem3_in;
      nlow3_ff <= nlow3_in;
      q3_ff    <= q3_in;
      pix4_ff  <= pix4_in;
      grey4_ff <= grey4_in;
      q4_ff    <= q4_in;
   end

   assign out_valid = v4_ff;

   always_comb begin
      out_data.pix  = pix4_ff;
      out_data.grey = grey4_ff;
      out_data.hue  = q4_ff;
   end

endmodule
`default_nettype wire

// ----- src/hwck_select.sv -----
`default_nettype none
module hwck_select (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hwck_pkg::cfg_type      cfg,
   input  wire logic                   in_valid,
   output logic                       in_stall,
   input  wire hwck_pkg::hue_item_type in_data,
   output logic                       out_valid,
   input  wire logic                   out_stall,
   output hwck_pkg::rsp_type           out_data
);

   logic              valid_ff, valid_in;
   hwck_pkg::rsp_type data_ff, data_in;
   logic              take;
   logic              ge_lo, le_hi, keep;

   assign take     = !valid_ff || !out_stall;
   assign in_stall = !take;

   always_comb begin
      ge_lo = (in_data.hue >= cfg.hue_lo);
      le_hi = (in_data.hue <= cfg.hue_hi);
      if (cfg.full_window) begin
         keep = 1'b1;
      end else if (cfg.hue_lo <= cfg.hue_hi) begin
         keep = ge_lo && le_hi;
      end else begin
         keep = ge_lo || le_hi;
      end

      data_in = data_ff;
      if (take) begin
         data_in.inside_window = keep;
         data_in.red_out   = keep ? in_data.pix.red_in   : in_data.grey;
         data_in.green_out = keep ? in_data.pix.green_in : in_data.grey;
         data_in.blue_out  = keep ? in_data.pix.blue_in  : in_data.grey;
      end
      valid_in = take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- bench/hue_window_color_keep_checker.sv -----
`timescale 1ns / 100ps
module hue_window_color_keep_checker
   import hwck_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  req_type                       req_data,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  rsp_type                       rsp_data,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data,
   output int                            mismatch_count,
   output int                            pending_count
);

   localparam int HUE_WRAP     = int'(HUE_FULL);
   localparam int HALF_LIMIT   = int'(HUE_HALF_MAX);
   localparam int SECTOR_STEPS = 960;
   localparam int REPORT_LIMIT = 10;

   logic [12:0] center_setting;
   logic [11:0] half_setting;
   logic [7:0]  red_weight;
   logic [7:0]  green_weight;
   logic [7:0]  blue_weight;

   rsp_type     kept_or_gray[$];

   function automatic logic [12:0] hue_of(input req_type pix);
      int r, g, b, brightest, darkest, chroma, offset;
      r = pix.red_in;
      g = pix.green_in;
      b = pix.blue_in;
      brightest = r;
      darkest = r;
      if (g > brightest) brightest = g;
      if (b > brightest) brightest = b;
      if (g < darkest) darkest = g;
      if (b < darkest) darkest = b;
      chroma = brightest - darkest;
      if (chroma == 0) begin
         return '0;
      end
      if (r == brightest) begin
         offset = g - b;
      end else if (g == brightest) begin
         offset = 2 * chroma + b - r;
      end else begin
         offset = 4 * chroma + r - g;
      end
      if (offset < 0) begin
         offset += 6 * chroma;
      end
      return 13'((offset * SECTOR_STEPS) / chroma);
   endfunction

   function automatic logic hue_in_window(input logic [12:0] hue);
      int centre, half, lower, upper, h;
      centre = int'(center_setting) % HUE_WRAP;
      half = (int'(half_setting) > HALF_LIMIT) ? HALF_LIMIT : int'(half_setting);
      h = int'(hue);
      if (half == HALF_LIMIT) begin
         return 1'b1;
      end
      lower = (centre + HUE_WRAP - half) % HUE_WRAP;
      upper = (centre + half) % HUE_WRAP;
      if (lower <= upper) begin
         return (h >= lower) && (h <= upper);
      end
      return (h >= lower) || (h <= upper);
   endfunction

   function automatic rsp_type filtered_pixel(input req_type pix);
      rsp_type outcome;
      int gray;
      if (hue_in_window(hue_of(pix))) begin
         outcome.red_out       = pix.red_in;
         outcome.green_out     = pix.green_in;
         outcome.blue_out      = pix.blue_in;
         outcome.inside_window = 1'b1;
      end else begin
         gray = (int'(red_weight) * int'(pix.red_in) + int'(green_weight) * int'(pix.green_in)
                 + int'(blue_weight) * int'(pix.blue_in)) >> 8;
         if (gray > 255) gray = 255;
         outcome.red_out       = 8'(gray);
         outcome.green_out     = 8'(gray);
         outcome.blue_out      = 8'(gray);
         outcome.inside_window = 1'b0;
      end
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         center_setting = RESET_HUE_CENTER;
         half_setting   = RESET_HUE_HALFWIDTH;
         red_weight     = RESET_WEIGHT_RED;
         green_weight   = RESET_WEIGHT_GREEN;
         blue_weight    = RESET_WEIGHT_BLUE;
         kept_or_gray.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HUE_CENTER: begin
                  center_setting = csr_data[12:0];
               end
               CSR_HUE_HALFWIDTH: begin
                  half_setting = csr_data[11:0];
               end
               CSR_WEIGHT_RED: begin
                  red_weight = csr_data[7:0];
               end
               CSR_WEIGHT_GREEN: begin
                  green_weight = csr_data[7:0];
               end
               CSR_WEIGHT_BLUE: begin
                  blue_weight = csr_data[7:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (kept_or_gray.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: result r=%0d g=%0d b=%0d keep=%0b with no item outstanding",
                           $realtime, rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out,
                           rsp_data.inside_window);
               end
            end else begin
               want = kept_or_gray.pop_front();
               if (rsp_data.red_out !== want.red_out || rsp_data.green_out !== want.green_out
                   || rsp_data.blue_out !== want.blue_out
                   || rsp_data.inside_window !== want.inside_window) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: expected r=%0d g=%0d b=%0d keep=%0b, got r=%0d g=%0d b=%0d keep=%0b",
                              $realtime, want.red_out, want.green_out, want.blue_out,
                              want.inside_window, rsp_data.red_out, rsp_data.green_out,
                              rsp_data.blue_out, rsp_data.inside_window);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            kept_or_gray.push_back(filtered_pixel(req_data));
         end
      end
      pending_count = kept_or_gray.size();
   end

endmodule

// ----- bench/hue_window_color_keep_tb.sv -----
`timescale 1ns / 100ps
module hue_window_color_keep_tb;
   import hwck_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd5;
   localparam int ITEMS_PER_PHASE  = 118;
   localparam int LONG_HOLD_CYCLES = 100;
   localparam int SETTLE_CYCLES    = 4;
   localparam int TAIL_CYCLES      = 10;
   localparam int WATCHDOG_LIMIT   = 1000;

   typedef enum int {STALL_NONE, STALL_SOLID, STALL_HALF, STALL_LIGHT} stall_style_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_type                 rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;
   int                      mismatch_count;
   int                      pending_count;
   int                      window_center = 0;
   int                      window_half = 480;
   bit                      long_hold_due = 1'b0;

   hue_window_color_keep dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   hue_window_color_keep_checker pixel_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type rgb(input int r, input int g, input int b);
      req_type pix;
      pix.red_in   = 8'(r);
      pix.green_in = 8'(g);
      pix.blue_in  = 8'(b);
      return pix;
   endfunction

   // Builds a pixel whose hue is the smallest one reachable at or above the target
   // for the given channel spread.
   function automatic req_type pixel_with_hue(input int target, input int chroma);
      int offset, dark, bright;
      offset = ((target * chroma + 959) / 960) % (6 * chroma);
      dark = $urandom_range(0, 255 - chroma);
      bright = dark + chroma;
      if (offset <= chroma) begin
         return rgb(bright, dark + offset, dark);
      end else if (offset <= 2 * chroma) begin
         return rgb(dark + 2 * chroma - offset, bright, dark);
      end else if (offset <= 3 * chroma) begin
         return rgb(dark, bright, dark + offset - 2 * chroma);
      end else if (offset <= 4 * chroma) begin
         return rgb(dark, dark + 4 * chroma - offset, bright);
      end else if (offset <= 5 * chroma) begin
         return rgb(dark + offset - 4 * chroma, dark, bright);
      end
      return rgb(bright, dark, dark + 6 * chroma - offset);
   endfunction

   function automatic int extreme_channel();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic req_type random_pixel();
      int pick, edge_hue, chroma, level, other;
      pick = $urandom_range(0, 99);
      chroma = ($urandom_range(0, 1) == 0) ? 240 : $urandom_range(1, 255);
      if (pick < 30) begin
         return rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 55) begin
         // Hues just around either edge of the current window.
         edge_hue = ($urandom_range(0, 1) == 0) ? window_center + window_half
                                                : window_center + 5760 - window_half;
         return pixel_with_hue((edge_hue + 5760 + $urandom_range(0, 8) - 4) % 5760, chroma);
      end else if (pick < 65) begin
         level = $urandom_range(0, 255);
         return rgb(level, level, level);
      end else if (pick < 75) begin
         level = $urandom_range(0, 255);
         other = $urandom_range(0, 255);
         case ($urandom_range(0, 2))
            0: return rgb(level, level, other);
            1: return rgb(level, other, level);
            default: return rgb(other, level, level);
         endcase
      end else if (pick < 85) begin
         return pixel_with_hue($urandom_range(0, 5759), chroma);
      end
      return rgb(extreme_channel(), extreme_channel(), extreme_channel());
   endfunction

   task automatic send_pixel(input req_type pix);
      req_valid <= 1'b1;
      req_data  <= pix;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Unused upper data bits carry random junk that the block must ignore.
   task automatic load_settings(input logic [12:0] center, input logic [11:0] half,
                                input logic [7:0] red_weight, input logic [7:0] green_weight,
                                input logic [7:0] blue_weight);
      write_reg(CSR_HUE_CENTER, center);
      write_reg(CSR_HUE_HALFWIDTH, {1'($urandom), half});
      write_reg(CSR_WEIGHT_RED, {5'($urandom), red_weight});
      write_reg(CSR_WEIGHT_GREEN, {5'($urandom), green_weight});
      write_reg(CSR_WEIGHT_BLUE, {5'($urandom), blue_weight});
      write_reg(CSR_SPARE_INDEX, 13'($urandom));
      csr_valid <= 1'b0;
      window_center = int'(center) % 5760;
      window_half = (int'(half) > 2880) ? 2880 : int'(half);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic stream_pixels(input int count, input bit hold_early, input bit drain_midway);
      int sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && sent < count) begin
            send_pixel(random_pixel());
            sent++;
            burst--;
            if (hold_early && sent == 20) long_hold_due = 1'b1;
            if (drain_midway && sent == count / 2) drain();
         end
         gap = $urandom_range(0, 10);
         if (gap > 0 && sent < count) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin : receiver
      stall_style_type style;
      int span;
      rsp_stall <= 1'b0;
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            style = stall_style_type'($urandom_range(0, 3));
            span = (style == STALL_SOLID) ? $urandom_range(1, 6) : $urandom_range(1, 24);
            repeat (span) begin
               case (style)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_SOLID: rsp_stall <= 1'b1;
                  STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
                  default:     rsp_stall <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("hue_window_color_keep test failed");
            $finish;
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Primaries, ties between channels, grays and hues on both edges of the
      // default window, which wraps past zero.
      send_pixel(rgb(0, 0, 0));
      send_pixel(rgb(255, 255, 255));
      send_pixel(rgb(255, 0, 0));
      send_pixel(rgb(0, 255, 0));
      send_pixel(rgb(0, 0, 255));
      send_pixel(rgb(255, 255, 0));
      send_pixel(rgb(0, 255, 255));
      send_pixel(rgb(255, 0, 255));
      send_pixel(rgb(128, 128, 128));
      send_pixel(rgb(255, 0, 1));
      send_pixel(rgb(1, 0, 0));
      send_pixel(rgb(0, 1, 0));
      send_pixel(rgb(255, 254, 255));
      send_pixel(rgb(0, 0, 1));
      send_pixel(pixel_with_hue(480, 240));
      send_pixel(pixel_with_hue(484, 240));
      send_pixel(pixel_with_hue(476, 240));
      send_pixel(pixel_with_hue(5280, 240));
      send_pixel(pixel_with_hue(5276, 240));
      send_pixel(pixel_with_hue(5284, 240));
      send_pixel(rgb(255, 127, 0));
      send_pixel(rgb(12, 200, 77));

      stream_pixels(ITEMS_PER_PHASE, 1'b1, 1'b0);
      drain();
      load_settings(13'd0, 12'd0, 8'd255, 8'd255, 8'd255);
      stream_pixels(ITEMS_PER_PHASE, 1'b0, 1'b1);
      drain();
      load_settings(13'd5759, 12'd2880, 8'd0, 8'd0, 8'd0);
      stream_pixels(ITEMS_PER_PHASE, 1'b0, 1'b0);
      drain();
      load_settings(13'd8191, 12'd4095, 8'd1, 8'd2, 8'd3);
      stream_pixels(ITEMS_PER_PHASE, 1'b0, 1'b0);
      drain();
      load_settings(13'd2879, 12'd2879, 8'd128, 8'd128, 8'd0);
      stream_pixels(ITEMS_PER_PHASE, 1'b0, 1'b0);
      drain();
      load_settings(13'd100, 12'd300, 8'd77, 8'd150, 8'd29);
      stream_pixels(ITEMS_PER_PHASE, 1'b0, 1'b0);
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         load_settings(13'($urandom_range(0, 8191)),
                       ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                   : 12'($urandom_range(0, 2880)),
                       8'($urandom), 8'($urandom), 8'($urandom));
         stream_pixels(ITEMS_PER_PHASE, 1'b0, 1'b0);
      end
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("hue_window_color_keep test passed");
      end else begin
         $display("hue_window_color_keep test failed");
      end
      $finish;
   end

endmodule
